// ===== hw/rtl/utf8_to_ucs2_decoder_defines.svh =====
// utf8_to_ucs2_decoder_defines.svh: assertion macros for the decoder RTL.
// Expects signals named clock and reset in the including scope.
`ifndef UTF8_TO_UCS2_DECODER_DEFINES_SVH
`define UTF8_TO_UCS2_DECODER_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define UTF8UCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define UTF8UCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/utf8ucs_pkg.sv =====
// utf8ucs_pkg: types and constants shared by the UTF-8 to UCS-2 decoder.
// No dependencies.
`default_nettype none

package utf8ucs_pkg;

   localparam logic [7:0]  MARK_ASCII  = 8'h80;
   localparam logic [7:0]  MARK_TWO    = 8'h20;
   localparam logic [7:0]  MARK_THREE  = 8'h10;
   localparam logic [7:0]  KEEP_TWO    = 8'h1f;
   localparam logic [7:0]  KEEP_THREE  = 8'h0f;
   localparam logic [7:0]  KEEP_TAIL   = 8'h3f;
   localparam logic [15:0] WIDE_SYMBOL = 16'h0058;

   // following bytes a lead announces, and bytes dropped after a wide lead
   localparam logic [1:0]  PEND_TWO    = 2'd1;
   localparam logic [1:0]  PEND_THREE  = 2'd2;
   localparam logic [1:0]  SKIP_WIDE   = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } request_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        truncated;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8ucs_core.sv =====
// utf8ucs_core: decoder state (pending count, skip count, accumulator) and the
// per-byte decode logic. Depends on utf8ucs_pkg and utf8_to_ucs2_decoder_defines.svh.
`default_nettype none

`include "utf8_to_ucs2_decoder_defines.svh"

module utf8ucs_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire utf8ucs_pkg::request_type request,
   output logic                          emit,
   output utf8ucs_pkg::result_type       result
);

   logic [1:0]  pend_ff, pend_in;
   logic [1:0]  skip_ff, skip_in;
   logic [15:0] acc_ff, acc_in;

   logic [7:0]  b;
   logic        emit_raw;
   logic [15:0] unit_raw;
   logic [1:0]  pend_raw;
   logic [1:0]  skip_raw;
   logic [15:0] acc_raw;

   assign b = request.in_byte;

   always_comb begin
      emit_raw = 1'b0;
      unit_raw = 16'h0000;
      pend_raw = pend_ff;
      skip_raw = skip_ff;
      acc_raw  = acc_ff;
      if (skip_ff != 2'd0) begin
         skip_raw = skip_ff - 2'd1;
      end else if (pend_ff != 2'd0) begin
         acc_raw  = {acc_ff[9:0], b[5:0] & utf8ucs_pkg::KEEP_TAIL[5:0]};
         pend_raw = pend_ff - 2'd1;
         if (pend_ff == 2'd1) begin
            emit_raw = 1'b1;
            unit_raw = acc_raw;
         end
      end else if ((b & utf8ucs_pkg::MARK_ASCII) == 8'h00) begin
         emit_raw = 1'b1;
         unit_raw = {8'h00, b};
      end else if ((b & utf8ucs_pkg::MARK_TWO) == 8'h00) begin
         acc_raw  = {8'h00, b & utf8ucs_pkg::KEEP_TWO};
         pend_raw = utf8ucs_pkg::PEND_TWO;
      end else if ((b & utf8ucs_pkg::MARK_THREE) == 8'h00) begin
         acc_raw  = {8'h00, b & utf8ucs_pkg::KEEP_THREE};
         pend_raw = utf8ucs_pkg::PEND_THREE;
      end else begin
         emit_raw = 1'b1;
         unit_raw = utf8ucs_pkg::WIDE_SYMBOL;
         skip_raw = utf8ucs_pkg::SKIP_WIDE;
      end
   end

   // end of buffer: report an unfinished sequence, then drop all state
   always_comb begin
      emit             = emit_raw;
      result.code_unit = unit_raw;
      result.truncated = 1'b0;
      pend_in          = pend_raw;
      skip_in          = skip_raw;
      acc_in           = acc_raw;
      if (request.end_of_buffer) begin
         if (pend_raw != 2'd0) begin
            emit             = 1'b1;
            result.code_unit = 16'h0000;
            result.truncated = 1'b1;
         end
         pend_in = 2'd0;
         skip_in = 2'd0;
         acc_in  = 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
         skip_ff <= 2'd0;
         acc_ff  <= 16'h0000;
      end else if (advance) begin
         pend_ff <= pend_in;
         skip_ff <= skip_in;
         acc_ff  <= acc_in;
      end
   end

   `UTF8UCS_ASSERT(a_skip_pend_excl,
      !(skip_ff != 2'd0 && pend_ff != 2'd0),
      "skip and pending both active")
   `UTF8UCS_ASSERT(a_eob_clears,
      advance && request.end_of_buffer |=>
         pend_ff == 2'd0 && skip_ff == 2'd0 && acc_ff == 16'h0000,
      "state not cleared after end of buffer")
   `UTF8UCS_ASSERT(a_skip_silent,
      advance && skip_ff != 2'd0 |-> !emit,
      "result produced while skipping")
   `UTF8UCS_ASSERT(a_trunc_only_eob,
      emit && result.truncated |-> request.end_of_buffer && result.code_unit == 16'h0000,
      "truncated result without end of buffer")

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_to_ucs2_decoder.sv =====
// utf8_to_ucs2_decoder: top level with request register and result register.
// Depends on utf8ucs_pkg and utf8ucs_core.
`default_nettype none

// Accepts one UTF-8 byte per cycle while req_stall is low and returns zero or one
// UCS-2 code unit for it. A byte that produces a result passes the request
// register, then the result register, before it shows on rsp_; the sustained rate
// is one byte per clock as long as rsp_stall stays low. The combinational decode
// between the two registers also updates the pending/skip/accumulator state, which
// is what sets that one-byte-per-cycle figure. A lead byte with bits 7, 5, 4 all set
// yields 0x58 and the next three bytes are dropped. With end_of_buffer set all
// state clears after that byte; an unfinished multibyte sequence at that point
// yields code unit 0 with rsp_truncated set.
module utf8_to_ucs2_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_buffer,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_code_unit,
   output logic             rsp_truncated
);

   logic                    in_valid_ff, in_valid_in;
   utf8ucs_pkg::request_type in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   utf8ucs_pkg::result_type out_data_ff;

   logic                    accept;
   logic                    advance;
   logic                    emit;
   utf8ucs_pkg::result_type result;

   // the held request moves on once the result register can take its result
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff.in_byte       <= req_in_byte;
         in_data_ff.end_of_buffer <= req_end_of_buffer;
      end
      if (advance && emit) begin
         out_data_ff <= result;
      end
   end

   utf8ucs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .request (in_data_ff),
      .emit    (emit),
      .result  (result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_unit = out_data_ff.code_unit;
   assign rsp_truncated = out_data_ff.truncated;

endmodule

`default_nettype wire

// ===== verif/utf8_to_ucs2_decoder_checker.sv =====
// utf8_to_ucs2_decoder_checker: watches the request and result channels of the decoder,
// predicts each code unit from the accepted bytes and compares field by field.
// Depends on utf8ucs_pkg.
module utf8_to_ucs2_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_buffer,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_code_unit,
   input  logic        rsp_truncated,
   output int          failures,
   output int          expected_left,
   output int          units_checked,
   output int          truncated_seen,
   output int          wide_seen
);

   // decoder state as the predictor sees it
   logic [1:0]  tail_left;
   logic [1:0]  skip_left;
   logic [15:0] partial;

   utf8ucs_pkg::result_type expected_units[$];

   function automatic void decode_request(input logic [7:0] data, input logic last);
      utf8ucs_pkg::result_type unit;
      logic       produce;
      produce = 1'b0;
      unit = '0;
      if (skip_left != 2'd0) begin
         skip_left = skip_left - 2'd1;
      end else if (tail_left != 2'd0) begin
         partial = (partial << 6) | {8'h00, data & utf8ucs_pkg::KEEP_TAIL};
         tail_left = tail_left - 2'd1;
         if (tail_left == 2'd0) begin
            produce = 1'b1;
            unit.code_unit = partial;
         end
      end else if ((data & utf8ucs_pkg::MARK_ASCII) == 8'h00) begin
         produce = 1'b1;
         unit.code_unit = {8'h00, data};
      end else if ((data & utf8ucs_pkg::MARK_TWO) == 8'h00) begin
         partial = {8'h00, data & utf8ucs_pkg::KEEP_TWO};
         tail_left = utf8ucs_pkg::PEND_TWO;
      end else if ((data & utf8ucs_pkg::MARK_THREE) == 8'h00) begin
         partial = {8'h00, data & utf8ucs_pkg::KEEP_THREE};
         tail_left = utf8ucs_pkg::PEND_THREE;
      end else begin
         // four-byte lead: substitute and drop what follows
         produce = 1'b1;
         unit.code_unit = utf8ucs_pkg::WIDE_SYMBOL;
         skip_left = utf8ucs_pkg::SKIP_WIDE;
         wide_seen++;
      end
      if (last) begin
         if (tail_left != 2'd0) begin
            produce = 1'b1;
            unit.code_unit = 16'h0000;
            unit.truncated = 1'b1;
            truncated_seen++;
         end
         tail_left = 2'd0;
         skip_left = 2'd0;
         partial = 16'h0000;
      end
      if (produce)
         expected_units.push_back(unit);
   endfunction

   always @(posedge clock) begin
      utf8ucs_pkg::result_type want;
      if (reset) begin
         tail_left = 2'd0;
         skip_left = 2'd0;
         partial = 16'h0000;
         expected_units.delete();
         failures = 0;
         units_checked = 0;
         truncated_seen = 0;
         wide_seen = 0;
      end else begin
         // predict first so a same-edge result would still find its entry
         if (req_valid && !req_stall)
            decode_request(req_in_byte, req_end_of_buffer);
         if (rsp_valid && !rsp_stall) begin
            if (expected_units.size() == 0) begin
               $error("unexpected result: code_unit %h truncated %b",
                      rsp_code_unit, rsp_truncated);
               failures++;
            end else begin
               want = expected_units.pop_front();
               units_checked++;
               if (rsp_code_unit !== want.code_unit) begin
                  $error("code_unit: expected %h, actual %h", want.code_unit, rsp_code_unit);
                  failures++;
               end
               if (rsp_truncated !== want.truncated) begin
                  $error("truncated: expected %b, actual %b", want.truncated, rsp_truncated);
                  failures++;
               end
            end
         end
      end
      expected_left = expected_units.size();
   end

endmodule

// ===== verif/tb_utf8_to_ucs2_decoder.sv =====
// tb_utf8_to_ucs2_decoder: drives UTF-8 bytes into the decoder with random gaps and
// back-pressure, and gives the verdict. Depends on utf8ucs_pkg,
// utf8_to_ucs2_decoder and utf8_to_ucs2_decoder_checker.
module tb_utf8_to_ucs2_decoder;

   localparam int ITEM_TARGET    = 550;
   localparam int SQUEEZE_AT     = 250;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_truncated;

   int failures, expected_left, units_checked, truncated_seen, wide_seen;
   int requests_sent = 0;
   int buffer_ends = 0;
   int idle_cycles = 0;
   logic steady = 1'b0;
   logic squeeze_req = 1'b0;

   always #10 clock = ~clock;

   utf8_to_ucs2_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_truncated     (rsp_truncated)
   );

   utf8_to_ucs2_decoder_checker u_checker (.*);

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // continuation byte, now and then without its 10xxxxxx mark
   function automatic logic [7:0] tail_byte();
      logic [31:0] r;
      r = $urandom;
      if (r[31:29] == 3'b000) return r[7:0];
      return {2'b10, r[5:0]};
   endfunction

   task automatic send_request(input logic [7:0] data, input logic last);
      int gap;
      gap = steady ? 0 : sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_byte <= data;
      req_end_of_buffer <= last;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (last) buffer_ends++;
   endtask

   task automatic send_sequence();
      logic [7:0]  seq[$];
      logic [31:0] r;
      int          kind;
      r = $urandom;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         seq.push_back({1'b0, r[6:0]});
      end else if (kind < 60) begin
         seq.push_back({1'b1, r[6], 1'b0, r[4:0]});
         seq.push_back(tail_byte());
      end else if (kind < 82) begin
         seq.push_back({1'b1, r[6], 2'b10, r[3:0]});
         seq.push_back(tail_byte());
         seq.push_back(tail_byte());
      end else if (kind < 94) begin
         seq.push_back({1'b1, r[6], 2'b11, r[3:0]});
         repeat (3) seq.push_back(8'($urandom_range(0, 255)));
      end else begin
         seq.push_back(r[15:8]);
      end
      foreach (seq[i])
         send_request(seq[i], $urandom_range(0, 99) < 5);
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ASCII extremes
      send_request(8'h00, 1'b0);
      send_request(8'h7f, 1'b0);
      // two-byte, including an 0x80..0x9F lead
      send_request(8'hc2, 1'b0);
      send_request(8'ha9, 1'b0);
      send_request(8'h9f, 1'b0);
      send_request(8'hbf, 1'b0);
      // three-byte at full scale, and an 0xA0..0xAF lead with unmarked tail
      send_request(8'hef, 1'b0);
      send_request(8'hff, 1'b0);
      send_request(8'hff, 1'b0);
      send_request(8'ha0, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h00, 1'b0);
      // four-byte lead, three bytes dropped
      send_request(8'hf0, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'h02, 1'b0);
      send_request(8'h03, 1'b0);
      // buffer ends inside two- and three-byte sequences
      send_request(8'hc3, 1'b1);
      send_request(8'he0, 1'b0);
      send_request(8'ha0, 1'b1);
      // buffer ends while dropping: nothing emitted for the last byte, state clear afterwards
      send_request(8'hf8, 1'b0);
      send_request(8'h80, 1'b1);
      send_request(8'h41, 1'b1);
      // buffer ends right on a completing byte
      send_request(8'hc2, 1'b0);
      send_request(8'h80, 1'b1);

      while (requests_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 8) steady = !steady;
         if (requests_sent >= SQUEEZE_AT && requests_sent < SQUEEZE_AT + 4)
            squeeze_req = 1'b1;
         send_sequence();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_left == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d buffers; checked %0d code units.",
               requests_sent, buffer_ends, units_checked);
      $display("Among them %0d truncated sequences and %0d wide substitutions.",
               truncated_seen, wide_seen);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : receiver
      int   span;
      logic hold;
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            // long hold-off so the block backs up into its input
            squeeze_req = 1'b0;
            hold = 1'b1;
            span = SQUEEZE_CYCLES;
         end else begin
            hold = ($urandom_range(0, 99) < 30);
            if (!hold && $urandom_range(0, 99) < 5)
               span = $urandom_range(60, 150);
            else if ($urandom_range(0, 99) < 85)
               span = $urandom_range(1, 3);
            else
               span = $urandom_range(10, 40);
         end
         rsp_stall <= hold;
         repeat (span - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $error("watchdog: no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
